// ===== hdl/rsap_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsap_pkg
// Shared constants, register indexes and types of the range splitter.
// ----------------------------------------------------------------------------
package rsap_pkg;

  localparam int NODES    = 4;
  localparam int NB       = NODES + 1;
  localparam int START_W  = 48;
  localparam int LEN_W    = 31;
  localparam int BND_W    = 48;
  localparam int EXT_W    = 49;
  localparam int CNT_W    = 3;
  localparam int NODE_W   = 2;
  localparam int BIDX_W   = 3;
  localparam int ADDR_W   = 6;
  localparam int DATA_W   = 64;
  localparam int IN_W     = 80;
  localparam int OUT_W    = 96;
  localparam int USER_W   = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(NODES);
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam logic [BIDX_W-1:0] REG_NODE_COUNT = 3'd0;
  localparam logic [BIDX_W-1:0] REG_BND_FIRST  = 3'd1;
  localparam logic [BIDX_W-1:0] REG_BND_LAST   = 3'd5;

  typedef logic [NB-1:0][BND_W-1:0] bnd_arr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FENCE,
    ST_LOW,
    ST_SRCH,
    ST_LOC,
    ST_END,
    ST_LEN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic             sub;
    logic [EXT_W-1:0] a;
    logic [EXT_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [EXT_W-1:0] value;
    logic             borrow;
  } alu_res_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [LEN_W-1:0]  loc;
    logic [LEN_W-1:0]  seg;
    logic [LEN_W-1:0]  pos;
    logic              found;
    logic              over;
    logic              last;
  } seg_t;

endpackage
`default_nettype wire

// ===== hdl/rsap_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsap_alu
// Shared 49-bit add/subtract unit; a subtract also reports its borrow.
// ----------------------------------------------------------------------------
module rsap_alu (
  input  rsap_pkg::alu_req_t req_i,
  output rsap_pkg::alu_res_t res_o
);
  import rsap_pkg::*;

  logic [EXT_W:0] sum;
  logic [EXT_W-1:0] opb;

  assign opb = req_i.sub ? ~req_i.b : req_i.b;
  assign sum = {1'b0, req_i.a} + {1'b0, opb} + {{EXT_W{1'b0}}, req_i.sub};

  assign res_o.value  = sum[EXT_W-1:0];
  assign res_o.borrow = req_i.sub & ~sum[EXT_W];

endmodule
`default_nettype wire

// ===== hdl/rsap_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsap_seq
// Sequencer: search and segment walk over the shared arithmetic unit,
// with the result output register.
// ----------------------------------------------------------------------------
module rsap_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rsap_pkg::bnd_arr_t              bnd_i,
  input  logic [rsap_pkg::CNT_W-1:0]      node_count_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rsap_pkg::START_W-1:0]    in_start_i,
  input  logic [rsap_pkg::LEN_W-1:0]      in_len_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rsap_pkg::seg_t                  out_seg_o
);
  import rsap_pkg::*;

  state_e state_q, state_d;

  logic [START_W-1:0] start_q, start_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [EXT_W-1:0]   fence_q, fence_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [NODE_W-1:0]  n_q, n_d;
  logic [EXT_W-1:0]   stop_q, stop_d;
  logic [START_W-1:0] cur_q, cur_d;
  logic [LEN_W-1:0]   pos_q, pos_d;
  logic [LEN_W-1:0]   seg_q, seg_d;
  logic [LEN_W-1:0]   loc_q, loc_d;
  logic               done_q, done_d;
  logic               found_q, found_d;
  logic               ovalid_q, ovalid_d;
  seg_t               oseg_q, oseg_d;

  alu_req_t           req;
  alu_res_t           res;
  logic [BIDX_W-1:0]  bidx;
  logic [BIDX_W-1:0]  n_next;
  logic [BND_W-1:0]   bsel;
  logic               last_node;
  logic               accept;
  logic               out_load;
  logic               over;
  logic               last;
  logic [CNT_W-1:0]   cnt_clamp;

  rsap_alu u_alu (
    .req_i (req),
    .res_o (res)
  );

  assign n_next    = {1'b0, n_q} + BIDX_W'(1);
  assign last_node = ({1'b0, n_next} >= {1'b0, cnt_q});
  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign out_load  = (state_q == ST_OUT) && (!ovalid_q || out_ready_i);
  assign over      = found_q && !done_q && last_node;
  assign last      = !found_q || done_q || over;
  assign bsel      = bnd_i[bidx];

  assign cnt_clamp = (node_count_i == '0) ? CNT_W'(1) :
                     (node_count_i > CNT_MAX) ? CNT_MAX : node_count_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_FENCE;
      ST_FENCE: state_d = ST_LOW;
      ST_LOW:   state_d = res.borrow ? ST_OUT : ST_SRCH;
      ST_SRCH: begin
        if (res.borrow) state_d = ST_LOC;
        else if (last_node) state_d = ST_OUT;
      end
      ST_LOC:   state_d = ST_END;
      ST_END:   state_d = ST_LEN;
      ST_LEN:   state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) state_d = last ? ST_IDLE : ST_END;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // operand selection
  always_comb begin
    req.sub = 1'b1;
    req.a   = {1'b0, start_q};
    req.b   = {1'b0, bsel};
    bidx    = n_next;
    case (state_q)
      ST_FENCE: begin
        req.sub = 1'b0;
        req.b   = {{(EXT_W-LEN_W){1'b0}}, len_q};
      end
      ST_LOW:   bidx = '0;
      ST_LOC:   bidx = {1'b0, n_q};
      ST_END: begin
        req.a = {1'b0, bsel};
        req.b = fence_q;
      end
      ST_LEN: begin
        req.a = stop_q;
        req.b = {1'b0, cur_q};
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    start_d  = start_q;
    len_d    = len_q;
    fence_d  = fence_q;
    cnt_d    = cnt_q;
    n_d      = n_q;
    stop_d   = stop_q;
    cur_d    = cur_q;
    pos_d    = pos_q;
    seg_d    = seg_q;
    loc_d    = loc_q;
    done_d   = done_q;
    found_d  = found_q;
    ovalid_d = ovalid_q && !out_ready_i;
    oseg_d   = oseg_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          start_d = in_start_i;
          len_d   = in_len_i;
          cnt_d   = cnt_clamp;
          n_d     = '0;
        end
      end
      ST_FENCE: fence_d = res.value;
      ST_LOW:   found_d = !res.borrow;
      ST_SRCH: begin
        if (res.borrow) found_d = 1'b1;
        else if (last_node) found_d = 1'b0;
        else n_d = n_next[NODE_W-1:0];
      end
      ST_LOC: begin
        cur_d = start_q;
        pos_d = '0;
        if (res.borrow) loc_d = '0;
        else if (res.value[EXT_W-1:LEN_W] != '0) loc_d = LEN_MAX;
        else loc_d = res.value[LEN_W-1:0];
      end
      ST_END: begin
        done_d = !res.borrow;
        stop_d = res.borrow ? {1'b0, bsel} : fence_q;
      end
      ST_LEN: begin
        if (res.borrow || res.value == '0) seg_d = '0;
        else seg_d = res.value[LEN_W-1:0];
      end
      ST_OUT: begin
        if (out_load) begin
          ovalid_d     = 1'b1;
          oseg_d.node  = found_q ? n_q : '0;
          oseg_d.loc   = found_q ? loc_q : '0;
          oseg_d.seg   = found_q ? seg_q : '0;
          oseg_d.pos   = found_q ? pos_q : '0;
          oseg_d.found = found_q;
          oseg_d.over  = over;
          oseg_d.last  = last;
          n_d          = n_next[NODE_W-1:0];
          loc_d        = '0;
          pos_d        = pos_q + seg_q;
          if (seg_q != '0) cur_d = stop_q[START_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    len_q   <= len_d;
    fence_q <= fence_d;
    cnt_q   <= cnt_d;
    n_q     <= n_d;
    stop_q  <= stop_d;
    cur_q   <= cur_d;
    pos_q   <= pos_d;
    seg_q   <= seg_d;
    loc_q   <= loc_d;
    done_q  <= done_d;
    found_q <= found_d;
    oseg_q  <= oseg_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_seg_o   = oseg_q;

endmodule
`default_nettype wire

// ===== hdl/range_split_across_partitions_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// range_split_across_partitions_core
// Splits a global range request against a table of partition boundaries.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel (start offset, length). For each
// request the block emits one segment per partition touched on m_axis, the
// final one with tlast set; a start outside the table gives a single
// segment with found clear. The user must write node count and boundaries
// over the APB port with no request in flight; the block does not check.
// Subtractions and the fence addition use one shared 49-bit add/subtract
// unit, at most one operation per cycle. A hit runs the fence addition,
// the check against the first boundary and s search steps (s is 1..4),
// then the local offset and, for each of its k segments (k is 1..4), the
// end and length steps before the output register is loaded; a miss stops
// after the boundary check or the search. s_axis_tready stays low until
// the last segment is loaded. A stalled receiver holds the output register
// and the sequencer waits before loading the next segment. Reset clears
// the sequencer and output valid, node_count to 1, boundaries to 0.
// ----------------------------------------------------------------------------
module range_split_across_partitions_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rsap_pkg::ADDR_W-1:0]    paddr,
  input  logic [rsap_pkg::DATA_W-1:0]    pwdata,
  output logic [rsap_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // start_offset[47:0], length[78:48], zero pad
  input  logic [rsap_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // node_index[1:0], local_offset[32:2], segment_length[63:33],
  // buffer_position[94:64], zero pad
  output logic [rsap_pkg::OUT_W-1:0]     m_axis_tdata,
  // found[0], overrun[1]
  output logic [rsap_pkg::USER_W-1:0]    m_axis_tuser,
  output logic                           m_axis_tlast
);
  import rsap_pkg::*;

  logic [CNT_W-1:0]  node_count_q;
  bnd_arr_t          bnd_q;
  logic [BIDX_W-1:0] reg_idx;
  logic [BIDX_W-1:0] bnd_idx;
  logic              wr_en;
  seg_t              seg;

  assign reg_idx = paddr[ADDR_W-1:3];
  assign bnd_idx = reg_idx - REG_BND_FIRST;
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CNT_W'(1);
      bnd_q        <= '0;
    end else if (wr_en) begin
      case (reg_idx) inside
        REG_NODE_COUNT:                node_count_q <= pwdata[CNT_W-1:0];
        [REG_BND_FIRST:REG_BND_LAST]:  bnd_q[bnd_idx] <= pwdata[BND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx) inside
      REG_NODE_COUNT:               prdata = {{(DATA_W-CNT_W){1'b0}}, node_count_q};
      [REG_BND_FIRST:REG_BND_LAST]: prdata = {{(DATA_W-BND_W){1'b0}}, bnd_q[bnd_idx]};
      default: ;
    endcase
  end

  rsap_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bnd_i        (bnd_q),
    .node_count_i (node_count_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_start_i   (s_axis_tdata[START_W-1:0]),
    .in_len_i     (s_axis_tdata[START_W+LEN_W-1:START_W]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_seg_o    (seg)
  );

  assign m_axis_tdata = {1'b0, seg.pos, seg.seg, seg.loc, seg.node};
  assign m_axis_tuser = {seg.over, seg.found};
  assign m_axis_tlast = seg.last;

`ifndef ASSERT_OFF
  // a miss is a single all-zero transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tdata == '0
      && !m_axis_tuser[1]))
    else $error("miss transaction not closed or not zero");

  // overrun only on the final segment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
    else $error("overrun without last");

  // a request keeps the sequencer busy, so ready drops once it is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready right after accepting a request");
`endif

endmodule
`default_nettype wire

// ===== bench/range_split_across_partitions_checker.sv =====
// ----------------------------------------------------------------------------
// range_split_across_partitions_checker
// Watches the APB and stream channels of the range splitter and checks them.
// ----------------------------------------------------------------------------
// Keeps its own copy of the node count and boundary table from the APB
// writes it sees. For every accepted request it works out the segments the
// block has to emit and queues them. Every accepted segment is compared field
// by field with the oldest queued one. The failure count and the number of
// segments still outstanding are handed to the testbench top.
// ----------------------------------------------------------------------------
module range_split_across_partitions_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rsap_pkg::ADDR_W-1:0]   paddr,
  input  logic [rsap_pkg::DATA_W-1:0]   pwdata,
  input  logic                          pready,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // start_offset[47:0], length[78:48], zero pad
  input  logic [rsap_pkg::IN_W-1:0]     s_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // node_index[1:0], local_offset[32:2], segment_length[63:33],
  // buffer_position[94:64], zero pad
  input  logic [rsap_pkg::OUT_W-1:0]    m_axis_tdata,
  // found[0], overrun[1]
  input  logic [rsap_pkg::USER_W-1:0]   m_axis_tuser,
  input  logic                          m_axis_tlast,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  import rsap_pkg::*;

  logic [CNT_W-1:0]  node_count_q;
  logic [BND_W-1:0]  boundary_q [NB];
  seg_t              expected_segments [$];
  int unsigned       fails = 0;
  logic [BIDX_W-1:0] reg_idx;
  seg_t              want;

  assign reg_idx = paddr[ADDR_W-1:3];

  function automatic void check_field(input string name, input logic [63:0] expected,
                                      input logic [63:0] actual);
    if (expected !== actual) begin
      $error("%s: expected %0d, actual %0d", name, expected, actual);
      fails++;
    end
  endfunction

  function automatic void split_range(input logic [START_W-1:0] start,
                                      input logic [LEN_W-1:0] len);
    logic [63:0] fence;
    logic [63:0] cursor;
    logic [63:0] node_end;
    logic [63:0] stop_at;
    logic [63:0] seg_len;
    logic [63:0] offset;
    logic [63:0] position;
    int unsigned nodes_used;
    int unsigned first;
    bit          hit;
    bit          done;
    bit          over;
    seg_t        seg;
    fence = 64'(start) + 64'(len);
    nodes_used = (node_count_q == 0) ? 1 : ((node_count_q > NODES) ? NODES : node_count_q);
    hit = 1'b0;
    first = 0;
    if (start >= boundary_q[0]) begin
      for (int n = 0; n < nodes_used; n++) begin
        if (!hit && start < boundary_q[n+1]) begin
          hit = 1'b1;
          first = n;
        end
      end
    end
    if (!hit) begin
      seg = '0;
      seg.last = 1'b1;
      expected_segments.push_back(seg);
      return;
    end
    cursor = 64'(start);
    for (int n = first; n < nodes_used; n++) begin
      node_end = 64'(boundary_q[n+1]);
      stop_at = (fence < node_end) ? fence : node_end;
      seg_len = (stop_at > cursor) ? stop_at - cursor : 64'd0;
      offset = 64'd0;
      done = (fence <= node_end);
      over = 1'b0;
      // local offset only on the first segment, clipped to the field range
      if (n == first && start > boundary_q[n]) begin
        offset = 64'(start) - 64'(boundary_q[n]);
        if (offset > 64'(LEN_MAX)) offset = 64'(LEN_MAX);
      end
      if (!done && n + 1 >= nodes_used) begin
        over = 1'b1;
        done = 1'b1;
      end
      position = cursor - 64'(start);
      seg.node  = NODE_W'(n);
      seg.loc   = offset[LEN_W-1:0];
      seg.seg   = seg_len[LEN_W-1:0];
      seg.pos   = position[LEN_W-1:0];
      seg.found = 1'b1;
      seg.over  = over;
      seg.last  = done;
      expected_segments.push_back(seg);
      cursor = cursor + seg_len;
      if (done) break;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q = CNT_W'(1);
      foreach (boundary_q[i]) boundary_q[i] = '0;
      expected_segments.delete();
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (reg_idx == REG_NODE_COUNT) begin
          node_count_q = pwdata[CNT_W-1:0];
        end else if (reg_idx >= REG_BND_FIRST && reg_idx <= REG_BND_LAST) begin
          boundary_q[reg_idx - REG_BND_FIRST] = pwdata[BND_W-1:0];
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_segments.size() == 0) begin
          $error("segment transaction with no request outstanding");
          fails++;
        end else begin
          want = expected_segments.pop_front();
          check_field("node_index", 64'(want.node), 64'(m_axis_tdata[1:0]));
          check_field("local_offset", 64'(want.loc), 64'(m_axis_tdata[32:2]));
          check_field("segment_length", 64'(want.seg), 64'(m_axis_tdata[63:33]));
          check_field("buffer_position", 64'(want.pos), 64'(m_axis_tdata[94:64]));
          check_field("found", 64'(want.found), 64'(m_axis_tuser[0]));
          check_field("overrun", 64'(want.over), 64'(m_axis_tuser[1]));
          check_field("last", 64'(want.last), 64'(m_axis_tlast));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        split_range(s_axis_tdata[START_W-1:0], s_axis_tdata[START_W +: LEN_W]);
      end
      pending_o <= expected_segments.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ===== bench/range_split_across_partitions_core_tb.sv =====
// ----------------------------------------------------------------------------
// range_split_across_partitions_core_tb
// Testbench top of the range splitter.
// ----------------------------------------------------------------------------
// Programs the partition table over APB, first with hand-picked tables and
// requests that hit the corner cases (misses on both sides, empty requests,
// ranges ending on a boundary, overrun, clipped local offset, empty and
// unordered partitions, out-of-range node counts, unmapped registers), then
// with random tables and mostly in-table random requests. Requests go out in
// bursts with random gaps while the segment side stalls on its own pattern.
// Checking is done by the checker instance; this module gives the verdict.
// ----------------------------------------------------------------------------
module range_split_across_partitions_core_tb;
  import rsap_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned SETTLE_CYCLES   = 24;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 50;
  localparam logic [63:0] MASK48          = 64'hFFFF_FFFF_FFFF;

  localparam logic [BIDX_W-1:0] REG_SPARE_LOW  = REG_BND_LAST + 3'd1;
  localparam logic [BIDX_W-1:0] REG_SPARE_HIGH = {BIDX_W{1'b1}};

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_HOLD
  } rx_mode_e;

  logic              clk;
  logic              rst_n         = 1'b0;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [DATA_W-1:0] pwdata        = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // start_offset[47:0], length[78:48], zero pad
  logic [IN_W-1:0]   s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b1;
  // node_index[1:0], local_offset[32:2], segment_length[63:33],
  // buffer_position[94:64], zero pad
  logic [OUT_W-1:0]  m_axis_tdata;
  // found[0], overrun[1]
  logic [USER_W-1:0] m_axis_tuser;
  logic              m_axis_tlast;

  int unsigned       fail_count;
  int unsigned       pending_segments;

  logic [CNT_W-1:0]  cfg_count = CNT_W'(1);
  logic [63:0]       cfg_bnd [NB];
  logic [63:0]       draft_bnd [NB];
  logic [63:0]       span;
  logic [63:0]       pick;
  logic [LEN_W-1:0]  req_len;
  logic [CNT_W-1:0]  draft_count;
  int unsigned       used;
  int unsigned       shape;
  int unsigned       kind;
  int unsigned       burst_left = 0;
  int unsigned       idle_cycles = 0;
  rx_mode_e          rx_mode = RX_FREE;
  int unsigned       rx_cycle = 0;
  int unsigned       rx_hold = 0;

  range_split_across_partitions_core i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  range_split_across_partitions_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending_segments)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // segment side: free running, coin flips or stretches of stall
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 150 == 0) rx_mode = rx_mode_e'($urandom_range(0, 2));
    if (rx_hold != 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE: m_axis_tready <= 1'b1;
        RX_COIN: m_axis_tready <= ($urandom_range(0, 2) != 0);
        default: begin
          m_axis_tready <= 1'b1;
          if ($urandom_range(0, 3) == 0) rx_hold = $urandom_range(1, 8);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [BIDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_table(input logic [CNT_W-1:0] count, input logic [63:0] b0,
                            input logic [63:0] b1, input logic [63:0] b2,
                            input logic [63:0] b3, input logic [63:0] b4);
    cfg_count  = count;
    cfg_bnd[0] = b0 & MASK48;
    cfg_bnd[1] = b1 & MASK48;
    cfg_bnd[2] = b2 & MASK48;
    cfg_bnd[3] = b3 & MASK48;
    cfg_bnd[4] = b4 & MASK48;
    write_reg(REG_NODE_COUNT, DATA_W'(count));
    for (int i = 0; i < NB; i++) begin
      write_reg(REG_BND_FIRST + BIDX_W'(i), cfg_bnd[i]);
    end
  endtask

  task automatic send_request(input logic [START_W-1:0] start, input logic [LEN_W-1:0] len);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({len, start});
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
  endtask

  // hold requests back until every segment is out and the block has settled
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_segments != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    foreach (cfg_bnd[i]) cfg_bnd[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // table as left by reset: everything misses
    send_request('0, '0);
    send_request('1, '1);
    wait_idle();

    load_table(CNT_W'(4), 64'd1000, 64'd2000, 64'd3000, 64'd4000, 64'd5000);
    send_request(48'd999, 31'd5);
    send_request(48'd1000, 31'd0);
    send_request(48'd1000, 31'd1000);
    send_request(48'd1900, 31'd200);
    send_request(48'd1100, 31'd10000);
    send_request(48'd2000, 31'd1);
    send_request(48'd4999, 31'd1);
    send_request(48'd4999, 31'd2);
    send_request(48'd5000, 31'd1);
    send_request(48'd2500, 31'd2500);
    wait_idle();

    // zero node count acts as one node, huge first partition
    load_table(CNT_W'(0), 64'd0, 64'h100_0000_0000, 64'hFFFF_FFFF_FFFF, 64'd7, 64'd9);
    send_request(48'hFF_FFFF_FFFF, LEN_MAX);
    send_request(48'd0, 31'd5);
    send_request(48'h100_0000_0000, 31'd1);
    wait_idle();

    // count above the node limit, empty partition in the middle
    load_table(CNT_W'(7), 64'h10, 64'h8000_0000_0000, 64'h8000_0000_0005,
               64'h8000_0000_0005, 64'hFFFF_FFFF_FFFF);
    send_request(48'hFFFF_FFFF_FFFE, LEN_MAX);
    send_request(48'h7FFF_FFFF_FFFF, 31'd100);
    send_request(48'hF, 31'd1);
    wait_idle();

    // unordered boundaries
    load_table(CNT_W'(5), 64'd100, 64'd300, 64'd200, 64'd400, 64'd50);
    send_request(48'd150, 31'd500);
    send_request(48'd310, 31'd10);
    send_request(48'd50, 31'd10);
    wait_idle();

    load_table(CNT_W'(2), 64'd0, 64'd10, 64'd20, 64'd30, 64'd40);
    write_reg(REG_SPARE_LOW, {$urandom, $urandom});
    write_reg(REG_SPARE_HIGH, {$urandom, $urandom});
    send_request(48'd5, 31'd100);
    send_request(48'd10, 31'd10);
    send_request(48'd25, 31'd4);
    wait_idle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      shape = $urandom_range(0, 3);
      draft_count = ($urandom_range(0, 7) == 0) ? CNT_W'($urandom_range(0, 7)) :
                                                  CNT_W'($urandom_range(1, NODES));
      draft_bnd[0] = {$urandom, $urandom} & 64'h7FFF_FFFF_FFFF;
      if ($urandom_range(0, 3) == 0) draft_bnd[0] = $urandom_range(0, 100);
      for (int i = 1; i < NB; i++) begin
        case (shape)
          0: draft_bnd[i] = draft_bnd[i-1] + $urandom_range(0, 3000);
          1: draft_bnd[i] = draft_bnd[i-1] + $urandom_range(0, 3);
          2: draft_bnd[i] = draft_bnd[i-1] + ({$urandom, $urandom} & 64'h1_FFFF_FFFF);
          default: draft_bnd[i] = {$urandom, $urandom} & MASK48;
        endcase
      end
      load_table(draft_count, draft_bnd[0], draft_bnd[1], draft_bnd[2], draft_bnd[3],
                 draft_bnd[4]);

      used = (cfg_count == 0) ? 1 : ((cfg_count > NODES) ? NODES : cfg_count);
      span = (cfg_bnd[used] > cfg_bnd[0]) ? cfg_bnd[used] - cfg_bnd[0] : 64'd64;
      repeat (ITEMS_PER_PHASE) begin
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
          // inside the table, lengths short, table-sized or anything
          pick = cfg_bnd[0] + ({$urandom, $urandom} % (span + 1));
          case ($urandom_range(0, 2))
            0: req_len = LEN_W'($urandom_range(0, 64));
            1: req_len = LEN_W'({$urandom, $urandom} % (span + 1));
            default: req_len = LEN_W'($urandom);
          endcase
        end else if (kind < 85) begin
          pick = cfg_bnd[$urandom_range(0, NODES)] + $urandom_range(0, 4) - 64'd2;
          req_len = LEN_W'($urandom_range(0, 8));
        end else begin
          pick = {$urandom, $urandom};
          req_len = LEN_W'($urandom);
        end
        send_request(pick[START_W-1:0], req_len);
      end
      wait_idle();
    end

    if (fail_count == 0 && pending_segments == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
